[rtl/core/barycentric_point_in_triangle_core_macros.svh]
// Assertion macros of the point-in-triangle core checker.
`ifndef BARYCENTRIC_POINT_IN_TRIANGLE_CORE_MACROS_SVH
`define BARYCENTRIC_POINT_IN_TRIANGLE_CORE_MACROS_SVH

// Plain clocked property, switched off while reset is asserted.
`define BPT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A stalled transfer keeps its valid and its payload until taken.
`define BPT_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, dat, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && !rdy) |=> (vld && $stable(dat))) else $error(msg);

`endif

[rtl/core/bpt_pkg.sv]
// Shared widths, types and helpers of the point-in-triangle core.
package bpt_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int COF_W       = PROD_W + 1;
  localparam int MUL_W       = COORD_WIDTH + COF_W;
  localparam int SUM_W       = MUL_W + 2;
  localparam int IN_TDATA_W  = ((12 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [COF_W-1:0]       cof_t;
  typedef logic signed [MUL_W-1:0]       mul_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  // Flags of one finished test.
  typedef struct packed {
    logic degenerate;
    logic inside_res;
  } result_t;

  // Cyclic index 0..2 for an argument 0..4.
  function automatic logic [1:0] wrap3(input logic [2:0] k);
    logic [2:0] w;
    w = (k >= 3'd3) ? k - 3'd3 : k;
    return w[1:0];
  endfunction

endpackage

[rtl/core/bpt_cofactor.sv]
// Two pipeline stages: coordinate products, then the nine signed cofactors.
module bpt_cofactor (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bpt_pkg::coord_t m_i  [3][3],
  input  bpt_pkg::coord_t p_i  [3],
  output logic            valid_o,
  input  logic            ready_i,
  output bpt_pkg::cof_t   cf_o [3][3],
  output bpt_pkg::coord_t m0_o [3],
  output bpt_pkg::coord_t p_o  [3]
);
  import bpt_pkg::*;

  logic   vld_a_q, vld_b_q;
  logic   rdy_a, rdy_b;
  prod_t  pos_d [3][3];
  prod_t  neg_d [3][3];
  prod_t  pos_q [3][3];
  prod_t  neg_q [3][3];
  coord_t m0_a_q [3];
  coord_t p_a_q  [3];
  cof_t   cf_q   [3][3];
  coord_t m0_b_q [3];
  coord_t p_b_q  [3];

  // Advance a stage when it is empty or its successor takes its item
  assign rdy_b   = !vld_b_q || ready_i;
  assign rdy_a   = !vld_a_q || rdy_b;
  assign ready_o = rdy_a;

  // Form both minor products of every element
  always_comb begin
    logic [1:0] r1, r2, c1, c2;
    r1 = '0; r2 = '0; c1 = '0; c2 = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        r1 = wrap3(3'(r + 1));
        r2 = wrap3(3'(r + 2));
        c1 = wrap3(3'(c + 1));
        c2 = wrap3(3'(c + 2));
        pos_d[r][c] = PROD_W'(m_i[r1][c1]) * PROD_W'(m_i[r2][c2]);
        neg_d[r][c] = PROD_W'(m_i[r1][c2]) * PROD_W'(m_i[r2][c1]);
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        vld_a_q <= valid_i;
      end
      if (rdy_b) begin
        vld_b_q <= vld_a_q;
      end
    end
  end

  // Product stage payload
  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pos_q[r][c] <= pos_d[r][c];
          neg_q[r][c] <= neg_d[r][c];
        end
        m0_a_q[r] <= m_i[0][r];
        p_a_q[r]  <= p_i[r];
      end
    end
  end

  // Cofactor stage payload
  always_ff @(posedge clk_i) begin
    if (rdy_b && vld_a_q) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          cf_q[r][c] <= COF_W'(pos_q[r][c]) - COF_W'(neg_q[r][c]);
        end
        m0_b_q[r] <= m0_a_q[r];
        p_b_q[r]  <= p_a_q[r];
      end
    end
  end

  assign valid_o = vld_b_q;
  assign cf_o    = cf_q;
  assign m0_o    = m0_b_q;
  assign p_o     = p_b_q;

endmodule

[rtl/core/bpt_dot.sv]
// Two pipeline stages: cofactor products, then the determinant and numerator sums.
module bpt_dot (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bpt_pkg::cof_t   cf_i [3][3],
  input  bpt_pkg::coord_t m0_i [3],
  input  bpt_pkg::coord_t p_i  [3],
  output logic            valid_o,
  input  logic            ready_i,
  output bpt_pkg::sum_t   det_o,
  output bpt_pkg::sum_t   num_o [3]
);
  import bpt_pkg::*;

  logic vld_c_q, vld_d_q;
  logic rdy_c, rdy_d;
  mul_t dprod_q [3];
  mul_t nprod_q [3][3];
  sum_t det_q;
  sum_t num_q [3];

  assign rdy_d   = !vld_d_q || ready_i;
  assign rdy_c   = !vld_c_q || rdy_d;
  assign ready_o = rdy_c;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else begin
      if (rdy_c) begin
        vld_c_q <= valid_i;
      end
      if (rdy_d) begin
        vld_d_q <= vld_c_q;
      end
    end
  end

  // Multiply first row by its cofactors and every cofactor row by the point
  always_ff @(posedge clk_i) begin
    if (rdy_c && valid_i) begin
      for (int j = 0; j < 3; j++) begin
        dprod_q[j] <= MUL_W'(m0_i[j]) * MUL_W'(cf_i[0][j]);
        for (int i = 0; i < 3; i++) begin
          nprod_q[i][j] <= MUL_W'(cf_i[i][j]) * MUL_W'(p_i[j]);
        end
      end
    end
  end

  // Add the three terms of each dot product
  always_ff @(posedge clk_i) begin
    if (rdy_d && vld_c_q) begin
      det_q <= SUM_W'(dprod_q[0]) + SUM_W'(dprod_q[1]) + SUM_W'(dprod_q[2]);
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= SUM_W'(nprod_q[i][0]) + SUM_W'(nprod_q[i][1])
                  + SUM_W'(nprod_q[i][2]);
      end
    end
  end

  assign valid_o = vld_d_q;
  assign det_o   = det_q;
  assign num_o   = num_q;

endmodule

[rtl/core/bpt_classify.sv]
// Final stage: range test of the numerators against the determinant, output register.
module bpt_classify (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  bpt_pkg::sum_t    det_i,
  input  bpt_pkg::sum_t    num_i [3],
  output logic             valid_o,
  input  logic             ready_i,
  output bpt_pkg::result_t res_o
);
  import bpt_pkg::*;

  logic    vld_q;
  logic    rdy;
  result_t res_d, res_q;

  assign rdy     = !vld_q || ready_i;
  assign ready_o = rdy;

  // Check each numerator lies strictly between zero and the determinant
  always_comb begin
    logic det_pos, ok;
    det_pos = (det_i > sum_t'(0));
    ok      = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (det_pos) begin
        ok = ok & (num_i[i] > sum_t'(0)) & (num_i[i] < det_i);
      end else begin
        ok = ok & (num_i[i] < sum_t'(0)) & (num_i[i] > det_i);
      end
    end
    res_d.degenerate = (det_i == sum_t'(0));
    res_d.inside_res = ok & !res_d.degenerate;
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= valid_i;
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

[rtl/core/barycentric_point_in_triangle_core.sv]
// Top level of the barycentric point-in-triangle test core.
//
// Use: each input transfer on s_axis carries three triangle vertices A, B, C
// and a query point P, twelve signed Q8.8 coordinates. Each one gives exactly
// one output transfer on m_axis with two flags: inside (P strictly inside the
// triangle's barycentric range) and degenerate (vertex matrix determinant is
// zero, inside then reads 0).
// Pipeline: five register stages (coordinate products, cofactors, cofactor
// products, dot-product sums, range test and output register).
// Throughput: one test per cycle when the output does not stall; a new item
// is taken every cycle unless m_axis_tready is held low and the stages fill.
// Stalls: each stage has its own valid bit and moves when empty or when its
// successor moves, so a held m_axis_tready fills empty stages before
// s_axis_tready drops; nothing is lost or repeated.
// Reset: rst_ni clears all valid bits; the core takes a transfer at the first
// edge after release, with no configuration to load.
module barycentric_point_in_triangle_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z (16 bits each)
  input  logic [bpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // inside_res, degenerate, then zero padding
  output logic [bpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import bpt_pkg::*;

  coord_t  m_in [3][3];
  coord_t  p_in [3];
  logic    cof_vld, cof_rdy;
  cof_t    cf [3][3];
  coord_t  m0 [3];
  coord_t  pp [3];
  logic    dot_vld, dot_rdy;
  sum_t    det;
  sum_t    num [3];
  result_t res;

  // Unpack the coordinates
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_in[r][c] = coord_t'(s_axis_tdata[(3 * r + c) * COORD_WIDTH +: COORD_WIDTH]);
      end
      p_in[r] = coord_t'(s_axis_tdata[(9 + r) * COORD_WIDTH +: COORD_WIDTH]);
    end
  end

  bpt_cofactor u_cofactor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .m_i     (m_in),
    .p_i     (p_in),
    .valid_o (cof_vld),
    .ready_i (cof_rdy),
    .cf_o    (cf),
    .m0_o    (m0),
    .p_o     (pp)
  );

  bpt_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cof_vld),
    .ready_o (cof_rdy),
    .cf_i    (cf),
    .m0_i    (m0),
    .p_i     (pp),
    .valid_o (dot_vld),
    .ready_i (dot_rdy),
    .det_o   (det),
    .num_o   (num)
  );

  bpt_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dot_vld),
    .ready_o (dot_rdy),
    .det_i   (det),
    .num_i   (num),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  // Pack the flags, lowest bit first
  assign m_axis_tdata = {(OUT_TDATA_W - 2)'(0), res.degenerate, res.inside_res};

endmodule

[rtl/core/bpt_checker.sv]
// Port-level checker of the point-in-triangle core, bound to the top level.
`include "barycentric_point_in_triangle_core_macros.svh"

module bpt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import bpt_pkg::*;

  // A stalled result holds
  `BPT_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata, "output changed while stalled")

  // A degenerate triangle never reports inside
  `BPT_ASSERT(a_degen_outside, clk_i, rst_ni, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]), "inside set on degenerate triangle")

  // Padding bits stay clear
  `BPT_ASSERT(a_pad_zero, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:2] == '0), "output padding not zero")

  // With the result register empty the input side is never blocked
  `BPT_ASSERT(a_empty_ready, clk_i, rst_ni, (!m_axis_tvalid && s_axis_tvalid) |-> s_axis_tready, "input stalled with empty output")

endmodule

bind barycentric_point_in_triangle_core bpt_checker u_bpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/barycentric_point_in_triangle_core_tb.sv]
// Self-checking testbench of the barycentric point-in-triangle core.
module barycentric_point_in_triangle_core_tb;
  import bpt_pkg::*;

  // Tracks the flags due for every accepted query and checks each returned transfer.
  class triangle_query_board;
    result_t flags_due[$];
    int      errors;
    int      n_checked;
    int      n_inside;
    int      n_degenerate;

    // Exact integer point-in-triangle test on one packed query.
    function result_t classify_query(logic [IN_TDATA_W-1:0] d);
      coord_t  cv;
      longint  m[3][3];
      longint  p[3];
      longint  cf[3][3];
      longint  det;
      longint  num;
      result_t r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cv = d[(i * 3 + j) * COORD_WIDTH +: COORD_WIDTH];
          m[i][j] = cv;
        end
      end
      for (int j = 0; j < 3; j++) begin
        cv = d[(9 + j) * COORD_WIDTH +: COORD_WIDTH];
        p[j] = cv;
      end
      // signed cofactors in cyclic form
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cf[i][j] = m[(i + 1) % 3][(j + 1) % 3] * m[(i + 2) % 3][(j + 2) % 3]
                   - m[(i + 1) % 3][(j + 2) % 3] * m[(i + 2) % 3][(j + 1) % 3];
        end
      end
      det = m[0][0] * cf[0][0] + m[0][1] * cf[0][1] + m[0][2] * cf[0][2];
      r.degenerate = (det == 0);
      r.inside_res = (det != 0);
      if (det != 0) begin
        // each numerator must sit strictly between zero and det
        for (int i = 0; i < 3; i++) begin
          num = cf[i][0] * p[0] + cf[i][1] * p[1] + cf[i][2] * p[2];
          if (det > 0) begin
            if (!(num > 0 && num < det)) r.inside_res = 1'b0;
          end else begin
            if (!(num < 0 && num > det)) r.inside_res = 1'b0;
          end
        end
      end
      return r;
    endfunction

    function void note_query(logic [IN_TDATA_W-1:0] d);
      flags_due.push_back(classify_query(d));
    endfunction

    function void check_flags(logic [OUT_TDATA_W-1:0] d);
      result_t want;
      if (flags_due.size() == 0) begin
        $display("%0t unexpected result transfer: got inside_res %0b degenerate %0b",
                 $time, d[0], d[1]);
        errors++;
        return;
      end
      want = flags_due.pop_front();
      n_checked++;
      if (want.inside_res) n_inside++;
      if (want.degenerate) n_degenerate++;
      if (d[0] !== want.inside_res) begin
        $display("%0t inside_res mismatch: expected %0b, got %0b",
                 $time, want.inside_res, d[0]);
        errors++;
      end
      if (d[1] !== want.degenerate) begin
        $display("%0t degenerate mismatch: expected %0b, got %0b",
                 $time, want.degenerate, d[1]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  triangle_query_board board = new();
  bit quiet;
  int n_sent;

  barycentric_point_in_triangle_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long; none in quiet stretches.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Pack a query, vertex A x in the lowest bits.
  function automatic logic [IN_TDATA_W-1:0] pack_query(input int ax, ay, az, bx, by, bz,
                                                       cx, cy, cz, px, py, pz);
    return {coord_t'(pz), coord_t'(py), coord_t'(px), coord_t'(cz), coord_t'(cy),
            coord_t'(cx), coord_t'(bz), coord_t'(by), coord_t'(bx), coord_t'(az),
            coord_t'(ay), coord_t'(ax)};
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return 1;
      4: return -1;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Offer one query, holding it until the transfer completes.
  task automatic send_query(input logic [IN_TDATA_W-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // Well-formed triangle with random weights, or a degenerate one, or noise, or extremes.
  task automatic send_random_query();
    int a[3];
    int b[3];
    int c[3];
    int p[3];
    int w[3];
    int lim;
    int kind;
    kind = $urandom_range(0, 99);
    lim  = ($urandom_range(0, 2) == 0) ? 255 : 8191;
    for (int j = 0; j < 3; j++) begin
      a[j] = $urandom_range(0, 2 * lim) - lim;
      b[j] = $urandom_range(0, 2 * lim) - lim;
      c[j] = $urandom_range(0, 2 * lim) - lim;
    end
    if (kind < 45) begin
      // point built from weights in (0,1), sometimes right on a boundary
      for (int i = 0; i < 3; i++) begin
        w[i] = $urandom_range(1, 255);
        if ($urandom_range(0, 9) == 0) w[i] = ($urandom_range(0, 1) == 0) ? 0 : 256;
      end
      for (int j = 0; j < 3; j++) p[j] = (w[0] * a[j] + w[1] * b[j] + w[2] * c[j]) >>> 8;
      send_query(pack_query(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2],
                            p[0], p[1], p[2]));
    end else if (kind < 60) begin
      // rank-deficient vertex matrix
      for (int j = 0; j < 3; j++) begin
        case ($urandom_range(0, 3))
          0: c[j] = a[j] + b[j];
          1: c[j] = a[j] - b[j];
          2: c[j] = 2 * a[j];
          default: c[j] = 0;
        endcase
        p[j] = $urandom_range(0, 2 * lim) - lim;
      end
      if ($urandom_range(0, 3) == 0) begin
        a[2] = 0;
        b[2] = 0;
        c[2] = 0;
      end
      send_query(pack_query(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2],
                            p[0], p[1], p[2]));
    end else if (kind < 85) begin
      send_query({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      send_query(pack_query(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                            pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                            pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()));
    end
  endtask

  // Note accepted queries first, then check returned flags.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_query(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) board.check_flags(m_axis_tdata);
    end
  end

  // Stall the result side at random.
  initial begin
    int n;
    m_axis_tready <= 1'b1;
    @(posedge clk_i);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Main sequence: reset, directed queries, random phases, drain.
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    quiet = 1'b1;
    n_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // degenerate extremes: all zero, all most negative, all most positive
    send_query('0);
    send_query({IN_TDATA_W{1'b1}} << 0 ^ {12{16'h7fff}});
    send_query({12{16'h7fff}});
    // unit simplex, positive det: inside, on a face, at a vertex, on an edge, outside
    send_query(pack_query(256, 0, 0, 0, 256, 0, 0, 0, 256, 64, 64, 64));
    send_query(pack_query(256, 0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64));
    send_query(pack_query(256, 0, 0, 0, 256, 0, 0, 0, 256, 256, 0, 0));
    send_query(pack_query(256, 0, 0, 0, 256, 0, 0, 0, 256, 128, 128, 0));
    send_query(pack_query(256, 0, 0, 0, 256, 0, 0, 0, 256, -64, 64, 64));
    send_query(pack_query(256, 0, 0, 0, 256, 0, 0, 0, 256, 200, 200, 200));
    // swapped rows, negative det
    send_query(pack_query(0, 256, 0, 256, 0, 0, 0, 0, 256, 64, 64, 64));
    send_query(pack_query(0, 256, 0, 256, 0, 0, 0, 0, 256, 0, 256, 0));
    send_query(pack_query(0, 256, 0, 256, 0, 0, 0, 0, 256, 64, 300, 64));
    // full-scale vertices
    send_query(pack_query(32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 1, 1, 1));
    send_query(pack_query(32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 32767, 32767, 32767));
    send_query(pack_query(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, -1, -1, -1));
    send_query(pack_query(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, -32768, -32768, -32768));
    send_query(pack_query(32767, -32768, 0, -32768, 32767, -1, 0, 1, -32768,
                          -32768, 32767, -32768));
    // collinear rows and a zero column
    send_query(pack_query(256, 512, 768, 512, 1024, 1536, 1, 2, 3, 10, 20, 30));
    send_query(pack_query(256, 0, 0, 0, 256, 0, 128, 128, 0, 64, 64, 0));

    // random phases, every third one quiet and the rest gappy traffic
    for (int ph = 0; ph < 10; ph++) begin
      quiet = (ph % 3 == 1);
      for (int k = 0; k < 115; k++) send_random_query();
    end
    s_axis_tvalid <= 1'b0;

    while (board.flags_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.flags_due.size() != 0) board.errors++;

    $display("Sent %0d queries, checked %0d results: %0d inside, %0d degenerate.",
             n_sent, board.n_checked, board.n_inside, board.n_degenerate);
    $display("Mix covered simplex edges, sign-flipped determinants and full-range noise.");
    if (board.errors == 0) begin
      $display("barycentric_point_in_triangle_core_tb: clean");
    end else begin
      $display("barycentric_point_in_triangle_core_tb: errors");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", board.flags_due.size());
    $display("barycentric_point_in_triangle_core_tb: errors");
    $finish;
  end

endmodule
